### design/smrng_pkg.sv
// Shared constants and types of the shuffled minimal standard generator.
`default_nettype none

package smrng_pkg;

    localparam int DATA_W        = 31;
    localparam int MULT_W        = 15;
    localparam int TABLE_ENTRIES = 32;

    localparam logic [MULT_W-1:0] LCG_MULT   = 15'd16807;
    localparam logic [DATA_W-1:0] LCG_MOD    = 31'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SEED_RESET = 31'd1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PRIME,
        ST_FILL,
        ST_HOLD,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic load;
        logic adv;
    } t_gen_ctrl;

endpackage

`default_nettype wire

### design/smrng_draw_if.sv
// Draw request channel: valid, ready and the range bound.
`default_nettype none

interface smrng_draw_if;
    logic                         valid;
    logic                         ready;
    logic [smrng_pkg::DATA_W-1:0] range_n;

    modport source (output valid, output range_n, input ready);
    modport sink   (input valid, input range_n, output ready);
endinterface

`default_nettype wire

### design/smrng_result_if.sv
// Result channel: valid, ready, raw and scaled values.
`default_nettype none

interface smrng_result_if;
    logic                         valid;
    logic                         ready;
    logic [smrng_pkg::DATA_W-1:0] raw_value;
    logic [smrng_pkg::DATA_W-1:0] scaled_value;

    modport source (output valid, output raw_value, output scaled_value, input ready);
    modport sink   (input valid, input raw_value, input scaled_value, output ready);
endinterface

`default_nettype wire

### design/smrng_ram.sv
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module smrng_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read and write in the same cycle at one address returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### design/smrng_gen.sv
// Multiplicative generator with a two-deep lookahead that also works out each value's slot.
`default_nettype none

module smrng_gen #(
    parameter int TABLE_ENTRIES = smrng_pkg::TABLE_ENTRIES
) (
    input  wire logic                             i_clk,
    input  wire smrng_pkg::t_gen_ctrl             i_ctrl,
    input  wire logic [smrng_pkg::DATA_W-1:0]     i_seed,
    output logic      [smrng_pkg::DATA_W-1:0]     o_value,
    output logic      [$clog2(TABLE_ENTRIES)-1:0] o_slot
);

    localparam int SLOT_W = $clog2(TABLE_ENTRIES);
    localparam int DW     = smrng_pkg::DATA_W;
    localparam int PROD_W = smrng_pkg::DATA_W + smrng_pkg::MULT_W;
    localparam int NDIV   = 1 + (2147483647 - 1) / TABLE_ENTRIES;

    logic [DW-1:0]     r_a1;
    logic [SLOT_W-1:0] r_a1_slot;
    logic [DW-1:0]     r_a2;
    logic [SLOT_W-1:0] w_a2_slot;
    logic [DW-1:0]     w_a2_next;

    function automatic logic [DW-1:0] lcg_next(input logic [DW-1:0] x);
        logic [PROD_W-1:0] p;
        logic [DW:0]       s;
        p = PROD_W'(x) * PROD_W'(smrng_pkg::LCG_MULT);
        // 2^31 is one more than the modulus, so the high part folds back in by addition.
        s = {1'b0, p[DW-1:0]} + (DW+1)'(p[PROD_W-1:DW]);
        if (s >= {1'b0, smrng_pkg::LCG_MOD}) begin
            s = s - {1'b0, smrng_pkg::LCG_MOD};
        end
        return s[DW-1:0];
    endfunction

    // The slot is the value divided by NDIV; count the slot boundaries it lies at or above.
    always_comb begin
        w_a2_slot = '0;
        for (int k = 1; k < TABLE_ENTRIES; k++) begin
            if ({1'b0, r_a2} >= (DW+1)'(k * NDIV)) begin
                w_a2_slot = w_a2_slot + SLOT_W'(1);
            end
        end
    end

    assign w_a2_next = lcg_next(r_a2);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_a2 <= i_seed;
        end else if (i_ctrl.adv) begin
            r_a1      <= r_a2;
            r_a1_slot <= w_a2_slot;
            r_a2      <= w_a2_next;
        end
    end

    assign o_value = r_a1;
    assign o_slot  = r_a1_slot;

endmodule

`default_nettype wire

### design/smrng_scale.sv
// Scaling pipeline: multiply by the range, exact division by 2^31-1, output register.
`default_nettype none

module smrng_scale (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [smrng_pkg::DATA_W-1:0] i_raw,
    input  wire logic [smrng_pkg::DATA_W-1:0] i_range,
    smrng_result_if.source                    o_result
);

    localparam int DW  = smrng_pkg::DATA_W;
    localparam int PW  = 2 * smrng_pkg::DATA_W;
    localparam logic [DW:0] ONE_MOD   = {1'b0, smrng_pkg::LCG_MOD};
    localparam logic [DW:0] TWICE_MOD = {smrng_pkg::LCG_MOD, 1'b0};

    logic          r_v2;
    logic          r_vo;
    logic [PW-1:0] r_prod;
    logic [DW-1:0] r_n2;
    logic [DW-1:0] r_raw2;
    logic [DW-1:0] r_raw_o;
    logic [DW-1:0] r_scaled_o;

    logic          w_out_adv;
    logic          w_s2_adv;
    logic [DW:0]   w_sum;
    logic [1:0]    w_extra;
    logic [DW:0]   w_quot;
    logic [DW-1:0] w_scaled;

    assign w_out_adv = !r_vo || o_result.ready;
    assign w_s2_adv  = !r_v2 || w_out_adv;
    assign o_ready   = w_s2_adv;

    // With P = hi*2^31 + lo, P = hi*M + (hi + lo), and hi + lo never exceeds 2M.
    always_comb begin
        w_sum = {1'b0, r_prod[PW-1:DW]} + {1'b0, r_prod[DW-1:0]};
        if (w_sum >= TWICE_MOD) begin
            w_extra = 2'd2;
        end else if (w_sum >= ONE_MOD) begin
            w_extra = 2'd1;
        end else begin
            w_extra = 2'd0;
        end
        w_quot = {1'b0, r_prod[PW-1:DW]} + (DW+1)'(w_extra);
        if ((r_n2 != '0) && (w_quot >= {1'b0, r_n2})) begin
            w_scaled = r_n2 - DW'(1);
        end else begin
            w_scaled = w_quot[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (w_s2_adv) begin
                r_v2 <= i_valid;
            end
            if (w_out_adv) begin
                r_vo <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_adv && i_valid) begin
            r_prod <= PW'(i_raw) * PW'(i_range);
            r_n2   <= i_range;
            r_raw2 <= i_raw;
        end
        if (w_out_adv && r_v2) begin
            r_raw_o    <= r_raw2;
            r_scaled_o <= w_scaled;
        end
    end

    assign o_result.valid        = r_vo;
    assign o_result.raw_value    = r_raw_o;
    assign o_result.scaled_value = r_scaled_o;

endmodule

`default_nettype wire

### design/shuffled_minimal_standard_rng_unit.sv
// Top level of the shuffled minimal standard random generator.
//
// Park-Miller generator (x <- 16807 x mod 2^31-1) behind a Bays-Durham shuffle table held in a
// one-port-read, one-port-write RAM. After reset, and after every write to the seed register,
// the block loads the seed, primes the generator, fills the table and reads back slot 0; no
// draw is accepted meanwhile. After that one draw is accepted every cycle while the result side
// does not stall, and its result passes the first stage, the product register and the output
// register in turn. The rate is set by the table loop: the word read for one draw carries
// the slot index that addresses the read for the next draw, one RAM read per cycle. Each result
// gives the raw 31-bit value, whose fraction is raw/(2^31-1), and floor(raw*n/(2^31-1)) for the
// requested bound n. A seed of zero, or of 2^31-1, is used as one.
`default_nettype none

module shuffled_minimal_standard_rng_unit #(
    parameter int TABLE_ENTRIES = smrng_pkg::TABLE_ENTRIES
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_seed_we,
    input  wire logic [smrng_pkg::DATA_W-1:0] i_seed_wdata,
    smrng_draw_if.sink                        i_draw,
    smrng_result_if.source                    o_result
);

    localparam int DW     = smrng_pkg::DATA_W;
    localparam int SLOT_W = $clog2(TABLE_ENTRIES);
    localparam int WORD_W = smrng_pkg::DATA_W + SLOT_W;
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 8);

    smrng_pkg::t_state    r_state;
    smrng_pkg::t_state    n_state;
    logic [CNT_W-1:0]     r_cnt;
    logic [CNT_W-1:0]     n_cnt;
    logic [DW-1:0]        r_seed;
    logic                 r_v1;
    logic [DW-1:0]        r_n1;

    smrng_pkg::t_gen_ctrl w_ctrl;
    logic [DW-1:0]        w_x0;
    logic [DW-1:0]        w_gen_value;
    logic [SLOT_W-1:0]    w_gen_slot;
    logic [WORD_W-1:0]    w_held_word;
    logic [DW-1:0]        w_held_raw;
    logic [SLOT_W-1:0]    w_held_slot;
    logic                 w_we;
    logic [SLOT_W-1:0]    w_waddr;
    logic                 w_re;
    logic [SLOT_W-1:0]    w_raddr;
    logic                 w_scale_ready;
    logic                 w_s1_adv;
    logic                 w_draw;

    assign w_x0 = ((r_seed == '0) || (r_seed == smrng_pkg::LCG_MOD)) ? DW'(1) : r_seed;

    assign w_held_raw  = w_held_word[WORD_W-1:SLOT_W];
    assign w_held_slot = w_held_word[SLOT_W-1:0];

    assign w_s1_adv     = !r_v1 || w_scale_ready;
    assign i_draw.ready = (r_state == smrng_pkg::ST_RUN) && w_s1_adv;
    assign w_draw       = i_draw.valid && i_draw.ready;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        w_ctrl  = '0;
        w_we    = 1'b0;
        w_waddr = w_held_slot;
        w_re    = 1'b0;
        w_raddr = w_held_slot;
        case (r_state)
            smrng_pkg::ST_LOAD: begin
                w_ctrl.load = 1'b1;
                n_cnt       = CNT_W'(1);
                n_state     = smrng_pkg::ST_PRIME;
            end
            smrng_pkg::ST_PRIME: begin
                w_ctrl.adv = 1'b1;
                if (r_cnt == '0) begin
                    n_cnt   = CNT_W'(TABLE_ENTRIES + 7);
                    n_state = smrng_pkg::ST_FILL;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            smrng_pkg::ST_FILL: begin
                // The last TABLE_ENTRIES warm-up values go in from the top slot down.
                w_ctrl.adv = 1'b1;
                if (r_cnt < CNT_W'(TABLE_ENTRIES)) begin
                    w_we    = 1'b1;
                    w_waddr = r_cnt[SLOT_W-1:0];
                end
                if (r_cnt == '0) begin
                    n_state = smrng_pkg::ST_HOLD;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            smrng_pkg::ST_HOLD: begin
                w_re    = 1'b1;
                w_raddr = '0;
                n_state = smrng_pkg::ST_RUN;
            end
            smrng_pkg::ST_RUN: begin
                // Old slot contents come out as the new held value while the fresh one goes in.
                if (w_draw) begin
                    w_ctrl.adv = 1'b1;
                    w_we       = 1'b1;
                    w_re       = 1'b1;
                end
            end
            default: begin
                n_state = smrng_pkg::ST_LOAD;
            end
        endcase
        if (i_seed_we) begin
            n_state = smrng_pkg::ST_LOAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smrng_pkg::ST_LOAD;
            r_cnt   <= '0;
            r_seed  <= smrng_pkg::SEED_RESET;
            r_v1    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_seed_we) begin
                r_seed <= i_seed_wdata;
            end
            if (w_s1_adv) begin
                r_v1 <= w_draw;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_draw) begin
            r_n1 <= i_draw.range_n;
        end
    end

    smrng_gen #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_gen (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl),
        .i_seed  (w_x0),
        .o_value (w_gen_value),
        .o_slot  (w_gen_slot)
    );

    smrng_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata ({w_gen_value, w_gen_slot}),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_held_word)
    );

    smrng_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_v1),
        .o_ready  (w_scale_ready),
        .i_raw    (w_held_raw),
        .i_range  (r_n1),
        .o_result (o_result)
    );

    a_draw_enters_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_draw |=> r_v1)
        else $error("accepted draw transaction did not reach the first stage");

    a_held_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == smrng_pkg::ST_RUN) |-> (w_held_slot <= SLOT_W'(TABLE_ENTRIES - 1)))
        else $error("held value points beyond the shuffle table");

    a_raw_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.raw_value != '0))
        else $error("result transaction carries a zero generator value");

endmodule

`default_nettype wire

### tb/shuffled_minimal_standard_rng_unit_tb.sv
// Self-checking testbench for the shuffled minimal standard random generator unit.
`timescale 1ns / 100ps

module shuffled_minimal_standard_rng_unit_tb;

    localparam int          CYCLE_LIMIT = 400000;
    localparam int          SETTLE_CYCLES = 6;
    localparam logic [30:0] FULL_MASK = 31'h7FFF_FFFF;
    localparam logic [31:0] SLOT_DIV = 32'd1 + (32'(smrng_pkg::LCG_MOD) - 32'd1)
                                       / smrng_pkg::TABLE_ENTRIES;

    typedef struct packed {
        logic [smrng_pkg::DATA_W-1:0] raw_value;
        logic [smrng_pkg::DATA_W-1:0] scaled_value;
    } t_draw_result;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_seed_we;
    logic [smrng_pkg::DATA_W-1:0] i_seed_wdata;

    smrng_draw_if   draw_ch ();
    smrng_result_if result_ch ();

    shuffled_minimal_standard_rng_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seed_we    (i_seed_we),
        .i_seed_wdata (i_seed_wdata),
        .i_draw       (draw_ch),
        .o_result     (result_ch)
    );

    // Own copy of the generator state, the shuffle table and the held word.
    logic [smrng_pkg::DATA_W-1:0] gen_word;
    logic [smrng_pkg::DATA_W-1:0] held_word;
    logic [smrng_pkg::DATA_W-1:0] shuffle_slots [smrng_pkg::TABLE_ENTRIES];

    t_draw_result pending_results [$];
    t_draw_result got_result;
    t_draw_result want_result;

    int  mismatches  = 0;
    int  cycle_count = 0;
    int  ready_stall = 0;
    bit  idle_en     = 1'b1;
    bit  ready_next;

    initial begin
        i_clk = 1'b0;
    end

    always #2 i_clk = ~i_clk;

    function automatic logic [smrng_pkg::DATA_W-1:0] minstd_next(
        input logic [smrng_pkg::DATA_W-1:0] x);
        logic [63:0] prod;
        prod = 64'(x) * 64'(smrng_pkg::LCG_MULT);
        return smrng_pkg::DATA_W'(prod % 64'(smrng_pkg::LCG_MOD));
    endfunction

    function automatic void reseed_model(input logic [smrng_pkg::DATA_W-1:0] seed_val);
        logic [smrng_pkg::DATA_W-1:0] x;
        x = seed_val;
        if (x == '0 || x == smrng_pkg::LCG_MOD) begin
            x = 31'd1;
        end
        // Eight discarded steps, then the table is filled from the top slot down.
        for (int j = smrng_pkg::TABLE_ENTRIES + 7; j >= 0; j--) begin
            x = minstd_next(x);
            if (j < smrng_pkg::TABLE_ENTRIES) begin
                shuffle_slots[j] = x;
            end
        end
        gen_word  = x;
        held_word = shuffle_slots[0];
    endfunction

    function automatic t_draw_result predict_draw(input logic [smrng_pkg::DATA_W-1:0] bound);
        t_draw_result res;
        logic [31:0]  slot;
        logic [63:0]  prod;
        gen_word = minstd_next(gen_word);
        slot = 32'(held_word) / SLOT_DIV;
        if (slot >= smrng_pkg::TABLE_ENTRIES) begin
            slot = smrng_pkg::TABLE_ENTRIES - 1;
        end
        held_word = shuffle_slots[slot];
        shuffle_slots[slot] = gen_word;
        res.raw_value = held_word;
        if (bound == '0) begin
            res.scaled_value = '0;
        end else begin
            prod = (64'(held_word) * 64'(bound)) / 64'(smrng_pkg::LCG_MOD);
            if (prod >= 64'(bound)) begin
                prod = 64'(bound) - 64'd1;
            end
            res.scaled_value = smrng_pkg::DATA_W'(prod);
        end
        return res;
    endfunction

    function automatic logic [smrng_pkg::DATA_W-1:0] random_bound();
        case ($urandom_range(0, 4))
            0:       return smrng_pkg::DATA_W'($urandom_range(0, 16));
            1:       return smrng_pkg::DATA_W'(32'd1 << $urandom_range(0, 30));
            2:       return FULL_MASK - smrng_pkg::DATA_W'($urandom_range(0, 16));
            default: return smrng_pkg::DATA_W'($urandom) & FULL_MASK;
        endcase
    endfunction

    task automatic note_mismatch(input string what, input logic [smrng_pkg::DATA_W-1:0] exp_v,
                                 input logic [smrng_pkg::DATA_W-1:0] act_v);
        mismatches++;
        if (mismatches <= 10) begin
            $display("Mismatch on %s: expected %0d, got %0d", what, exp_v, act_v);
        end
    endtask

    // Checks every result transaction against the oldest prediction.
    always @(posedge i_clk) begin
        if (result_ch.valid && result_ch.ready) begin
            got_result.raw_value    = result_ch.raw_value;
            got_result.scaled_value = result_ch.scaled_value;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Unexpected result: raw %0d, scaled %0d",
                             got_result.raw_value, got_result.scaled_value);
                end
            end else begin
                want_result = pending_results.pop_front();
                if (got_result.raw_value !== want_result.raw_value) begin
                    note_mismatch("raw_value", want_result.raw_value, got_result.raw_value);
                end
                if (got_result.scaled_value !== want_result.scaled_value) begin
                    note_mismatch("scaled_value", want_result.scaled_value,
                                  got_result.scaled_value);
                end
            end
        end
    end

    // Result back-pressure in random bursts, switched off for the final phase.
    always @(negedge i_clk) begin
        if (ready_stall > 0) begin
            ready_stall--;
            ready_next = 1'b0;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            ready_stall = $urandom_range(1, 11) - 1;
            ready_next  = 1'b0;
        end else begin
            ready_next = 1'b1;
        end
        result_ch.ready <= ready_next;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_draw(input logic [smrng_pkg::DATA_W-1:0] bound);
        int gap;
        if (idle_en && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 11);
            @(negedge i_clk);
            draw_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        draw_ch.valid   <= 1'b1;
        draw_ch.range_n <= bound;
        do begin
            @(posedge i_clk);
        end while (!(draw_ch.valid && draw_ch.ready));
        pending_results.push_back(predict_draw(bound));
    endtask

    // Lowers valid and waits until every predicted result has come back.
    task automatic drain_results();
        @(negedge i_clk);
        draw_ch.valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [smrng_pkg::DATA_W-1:0] seed_val);
        drain_results();
        @(negedge i_clk);
        i_seed_we    <= 1'b1;
        i_seed_wdata <= seed_val;
        reseed_model(seed_val);
        @(negedge i_clk);
        i_seed_we <= 1'b0;
    endtask

    task automatic test_reset_seed();
        logic [smrng_pkg::DATA_W-1:0] bounds [10];
        bounds = '{31'd0, 31'd1, 31'd2, 31'd3, FULL_MASK, 31'h7FFF_FFFE,
                   31'h4000_0000, 31'h5555_5555, 31'h2AAA_AAAA, 31'd1000};
        foreach (bounds[i]) begin
            send_draw(bounds[i]);
        end
    endtask

    task automatic test_seed_extremes();
        logic [smrng_pkg::DATA_W-1:0] seeds [4];
        seeds = '{31'd0, FULL_MASK, 31'h7FFF_FFFE, 31'd1};
        foreach (seeds[i]) begin
            write_seed(seeds[i]);
            send_draw(FULL_MASK);
            send_draw(31'd0);
            send_draw(31'd7);
        end
    endtask

    // The sender stops mid-stream until the block has delivered everything.
    task automatic test_sender_pause();
        write_seed(31'd12345);
        for (int i = 0; i < 20; i++) begin
            send_draw(random_bound());
        end
        drain_results();
        for (int i = 0; i < 20; i++) begin
            send_draw(random_bound());
        end
    endtask

    task automatic test_random_seeds();
        for (int p = 0; p < 8; p++) begin
            write_seed(smrng_pkg::DATA_W'($urandom) & FULL_MASK);
            for (int i = 0; i < 100; i++) begin
                send_draw(random_bound());
            end
        end
    endtask

    task automatic test_full_rate();
        drain_results();
        idle_en = 1'b0;
        write_seed(smrng_pkg::DATA_W'($urandom) & FULL_MASK);
        for (int i = 0; i < 150; i++) begin
            send_draw(random_bound());
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_seed_we       = 1'b0;
        i_seed_wdata    = '0;
        draw_ch.valid   = 1'b0;
        draw_ch.range_n = '0;
        reseed_model(smrng_pkg::SEED_RESET);
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_seed();
        test_seed_extremes();
        test_sender_pause();
        test_random_seeds();
        test_full_rate();
        drain_results();

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### filelist.f
design/smrng_pkg.sv
design/smrng_draw_if.sv
design/smrng_result_if.sv
design/smrng_ram.sv
design/smrng_gen.sv
design/smrng_scale.sv
design/shuffled_minimal_standard_rng_unit.sv
tb/shuffled_minimal_standard_rng_unit_tb.sv
